FILE: hw/rtl/sorted_set_binary_search_assert.svh
// Assertion macros for the sorted set search block.
`ifndef SORTED_SET_BINARY_SEARCH_ASSERT_SVH
`define SORTED_SET_BINARY_SEARCH_ASSERT_SVH

`ifndef SYNTHESIS

`define SSBS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define SSBS_ASSERT_NEVER(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);

`else

`define SSBS_ASSERT(lbl, clk, rst_n, prop, msg)

`define SSBS_ASSERT_NEVER(lbl, clk, rst_n, prop, msg)

`endif

`endif

FILE: hw/rtl/ssbs_pkg.sv
package ssbs_pkg;

  localparam int CAPACITY = 1024;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int VAL_W    = 32;
  localparam int POS_W    = 11;

  typedef enum logic [1:0] {
    KIND_LOAD   = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_CLEAR  = 2'd2
  } ssbs_kind_e;

  typedef struct packed {
    logic [1:0]              kind;
    logic signed [VAL_W-1:0] value;
  } ssbs_item_t;

  typedef struct packed {
    logic             found;
    logic [POS_W-1:0] position;
    logic             overflow;
  } ssbs_result_t;

  // per-cell control: insert strobe, cell holds a live entry, cell is the first free slot
  typedef struct packed {
    logic ld;
    logic vld;
    logic tail;
  } ssbs_cell_ctl_t;

  typedef struct packed {
    logic             fin;
    logic             hit;
    logic [POS_W-1:0] pos;
  } ssbs_seq_res_t;

endpackage

FILE: hw/rtl/ssbs_cell.sv
module ssbs_cell (
  input  logic                              clk_i,
  input  ssbs_pkg::ssbs_cell_ctl_t          ctl_i,
  input  logic signed [ssbs_pkg::VAL_W-1:0] bus_i,
  input  logic signed [ssbs_pkg::VAL_W-1:0] prev_val_i,
  input  logic                              prev_gt_i,
  output logic signed [ssbs_pkg::VAL_W-1:0] val_o,
  output logic                              gt_o,
  output logic                              eq_o
);
  import ssbs_pkg::*;

  logic signed [VAL_W-1:0] val_q, val_d;

  always_comb begin
    gt_o  = ctl_i.vld && (val_q > bus_i);
    eq_o  = (val_q == bus_i);
    val_o = val_q;
    val_d = val_q;
    // shift up from the left neighbour when it also outranks the new item
    if (ctl_i.ld && (gt_o || ctl_i.tail)) begin
      val_d = prev_gt_i ? prev_val_i : bus_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

endmodule

FILE: hw/rtl/ssbs_seq.sv
module ssbs_seq (
  input  logic                           clk_i,
  input  logic                           go_i,
  input  logic [ssbs_pkg::CAPACITY-1:0]  eq_i,
  input  logic [ssbs_pkg::CAPACITY-1:0]  gt_i,
  input  logic [ssbs_pkg::CNT_W-1:0]     count_i,
  output ssbs_pkg::ssbs_seq_res_t        res_o
);
  import ssbs_pkg::*;

  logic [CAPACITY-1:0] eq_q, gt_q;
  logic [CNT_W-1:0]    lo_q, lo_d, hi_q, hi_d;
  logic [CNT_W:0]      sum;
  logic [CNT_W-1:0]    mid;
  logic [IDX_W-1:0]    idx;
  logic                empty, hit;

  // window is [lo, hi); mid = floor((lo + hi - 1) / 2)
  always_comb begin
    sum   = {1'b0, lo_q} + {1'b0, hi_q} - {{CNT_W{1'b0}}, 1'b1};
    mid   = sum[CNT_W:1];
    idx   = mid[IDX_W-1:0];
    empty = (lo_q >= hi_q);
    hit   = !empty && eq_q[idx];
    res_o.fin = empty || hit;
    res_o.hit = hit;
    res_o.pos = hit ? POS_W'({1'b0, mid} + {{CNT_W{1'b0}}, 1'b1}) : '0;
    lo_d = lo_q;
    hi_d = hi_q;
    if (go_i) begin
      lo_d = '0;
      hi_d = count_i;
    end else if (!res_o.fin) begin
      if (gt_q[idx]) begin
        hi_d = mid;
      end else begin
        lo_d = CNT_W'({1'b0, mid} + {{CNT_W{1'b0}}, 1'b1});
      end
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d;
    hi_q <= hi_d;
    if (go_i) begin
      eq_q <= eq_i;
      gt_q <= gt_i;
    end
  end

endmodule

FILE: hw/rtl/sorted_set_binary_search.sv
// Sorted set with binary search. Items are taken when start_i is high and busy_o is low.
// A load inserts its value through the row of sorting cells (after any equal values) and
// the next item may follow in the next cycle; a load into a full set gives one result with
// overflow set on the cycle after it is taken. A clear gives no result. A search compares
// the key against every cell when it is taken, then walks the binary search one midpoint
// per cycle: busy_o stays high while it probes (at most clog2(count+1) probes) and while
// it finds the window empty when the key is missed; the result is registered and shows
// as busy_o falls.
// Each result is on result_o for exactly one cycle, marked by valid_o; the receiver must
// take it then, as the block never holds a result back.
`include "sorted_set_binary_search_assert.svh"

module sorted_set_binary_search (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  ssbs_pkg::ssbs_item_t   item_i,
  output logic                   busy_o,
  output logic                   valid_o,
  output ssbs_pkg::ssbs_result_t result_o
);
  import ssbs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SRCH = 2'b10
  } ssbs_state_e;

  ssbs_state_e   state_q, state_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic          ovf_q, ovf_d;
  logic          valid_q, valid_d;
  ssbs_result_t  result_q, result_d;

  logic          accept, full, ld, go;
  ssbs_seq_res_t seq_res;

  logic signed [VAL_W-1:0] cell_val [CAPACITY];
  logic [CAPACITY-1:0]     cell_gt, cell_eq;

  assign busy_o   = (state_q != ST_IDLE);
  assign valid_o  = valid_q;
  assign result_o = result_q;
  assign accept   = start_i && !busy_o;
  assign full     = (count_q >= CNT_W'(CAPACITY));
  assign ld       = accept && (item_i.kind == KIND_LOAD) && !full;
  assign go       = accept && (item_i.kind == KIND_SEARCH);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    ssbs_cell_ctl_t ctl;
    logic signed [VAL_W-1:0] prev_val;
    logic prev_gt;

    assign ctl.ld   = ld;
    assign ctl.vld  = (CNT_W'(i) < count_q);
    assign ctl.tail = (CNT_W'(i) == count_q);

    if (i == 0) begin : g_head
      assign prev_val = '0;
      assign prev_gt  = 1'b0;
    end else begin : g_body
      assign prev_val = cell_val[i-1];
      assign prev_gt  = cell_gt[i-1];
    end

    ssbs_cell u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .bus_i      (item_i.value),
      .prev_val_i (prev_val),
      .prev_gt_i  (prev_gt),
      .val_o      (cell_val[i]),
      .gt_o       (cell_gt[i]),
      .eq_o       (cell_eq[i])
    );
  end

  ssbs_seq u_seq (
    .clk_i   (clk_i),
    .go_i    (go),
    .eq_i    (cell_eq),
    .gt_i    (cell_gt),
    .count_i (count_q),
    .res_o   (seq_res)
  );

  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ovf_d    = ovf_q;
    valid_d  = 1'b0;
    result_d = result_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (item_i.kind)
            KIND_LOAD: begin
              if (full) begin
                ovf_d             = 1'b1;
                valid_d           = 1'b1;
                result_d.found    = 1'b0;
                result_d.position = '0;
                result_d.overflow = 1'b1;
              end else begin
                count_d = count_q + CNT_W'(1);
              end
            end
            KIND_SEARCH: begin
              state_d = ST_SRCH;
            end
            KIND_CLEAR: begin
              count_d = '0;
              ovf_d   = 1'b0;
            end
            default: ;
          endcase
        end
      end
      ST_SRCH: begin
        if (seq_res.fin) begin
          valid_d           = 1'b1;
          result_d.found    = seq_res.hit;
          result_d.position = seq_res.pos;
          result_d.overflow = ovf_q;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
      ovf_q   <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      ovf_q   <= ovf_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    result_q <= result_d;
  end

  `SSBS_ASSERT(a_hit_pos, clk_i, rst_ni, valid_o && result_o.found |-> result_o.position != '0, "hit with zero position")
  `SSBS_ASSERT(a_miss_pos, clk_i, rst_ni, valid_o && !result_o.found |-> result_o.position == '0, "miss with nonzero position")
  `SSBS_ASSERT_NEVER(a_count_cap, clk_i, rst_ni, count_q > CNT_W'(CAPACITY), "element count above capacity")

endmodule
